/* hw/rtl/stg_pkg.sv */
// Package for the swept tone generator: shared constants, codes, structs and
// the quarter-wave sine table builder. No dependencies.
package stg_pkg;

  localparam int unsigned PHASE_BITS     = 32;
  localparam int unsigned COUNT_BITS     = 32;
  localparam int unsigned SINE_ADDR_BITS = 10;
  localparam int unsigned FULL_SCALE     = 32767;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam logic [2:0] WAVE_SINE     = 3'd0;
  localparam logic [2:0] WAVE_SQUARE   = 3'd1;
  localparam logic [2:0] WAVE_SAWTOOTH = 3'd2;
  localparam logic [2:0] WAVE_TRIANGLE = 3'd3;
  localparam logic [2:0] WAVE_SILENCE  = 3'd4;

  localparam logic [2:0] RAMP_OFF    = 3'd0;
  localparam logic [2:0] RAMP_UP     = 3'd1;
  localparam logic [2:0] RAMP_DOWN   = 3'd2;
  localparam logic [2:0] RAMP_BOUNCE = 3'd3;

  localparam logic [2:0] REG_WAVEFORM_SELECT = 3'd0;
  localparam logic [2:0] REG_AMPLITUDE       = 3'd1;
  localparam logic [2:0] REG_FIXED_INCREMENT = 3'd2;
  localparam logic [2:0] REG_SWEEP_MODE      = 3'd3;
  localparam logic [2:0] REG_START_INCREMENT = 3'd4;
  localparam logic [2:0] REG_END_INCREMENT   = 3'd5;
  localparam logic [2:0] REG_RAMP_PERIOD     = 3'd6;
  localparam logic [2:0] REG_SECTION_LENGTH  = 3'd7;

  typedef struct packed {
    logic [2:0]  waveform_select;
    logic [15:0] amplitude;
    logic [31:0] fixed_increment;
    logic [2:0]  sweep_mode;
    logic [31:0] start_increment;
    logic [31:0] end_increment;
    logic [31:0] ramp_period;
    logic [31:0] section_length;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic restart;
    logic wave;
    logic mul1;
    logic mul2;
    logic div_load;
    logic div_step;
    logic psel;
    logic offset;
    logic inc;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic div_needed;
    logic div_last;
  } status_t;

  // Q15 value of sin(pi/2 * k / 2^abits) by an integer Taylor series.
  function automatic logic [15:0] sine_entry(int unsigned k, int unsigned abits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic [63:0] v;
    x = (64'(k) * HALF_PI_Q30) >> abits;
    x2 = (x * x) >> 30;
    term = x;
    sum = $signed(x);
    for (int unsigned n = 1; n <= 8; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n[0]) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    v = (64'(sum) + 64'd16384) >> 15;
    if (v > 64'd32768) begin
      v = 64'd32768;
    end
    return v[15:0];
  endfunction

endpackage

/* hw/rtl/stg_sine_rom.sv */
// Quarter-wave sine ROM with registered read.
// Depends on stg_pkg for the table builder.
module stg_sine_rom #(
  parameter int unsigned ADDR_BITS = stg_pkg::SINE_ADDR_BITS
) (
  input  logic                 clk_i,
  input  logic [ADDR_BITS-1:0] addr_i,
  output logic [15:0]          data_o
);

  localparam int unsigned DEPTH = 1 << ADDR_BITS;

  logic [15:0] rom_tab [DEPTH];
  logic [15:0] data_q;

  for (genvar k = 0; k < DEPTH; k++) begin : g_tab
    localparam logic [15:0] ENTRY = stg_pkg::sine_entry(k, ADDR_BITS);
    assign rom_tab[k] = ENTRY;
  end

  always_ff @(posedge clk_i) begin
    data_q <= rom_tab[addr_i];
  end

  assign data_o = data_q;

endmodule

/* hw/rtl/stg_regs.sv */
// Configuration register bank of the swept tone generator.
// Depends on stg_pkg for register indexes and the cfg_t struct.
module stg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [2:0]    cfg_index_i,
  input  logic [31:0]   cfg_data_i,
  output stg_pkg::cfg_t cfg_o
);

  stg_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.waveform_select <= stg_pkg::WAVE_SILENCE;
      cfg_q.amplitude       <= '0;
      cfg_q.fixed_increment <= '0;
      cfg_q.sweep_mode      <= '0;
      cfg_q.start_increment <= '0;
      cfg_q.end_increment   <= '0;
      cfg_q.ramp_period     <= '0;
      cfg_q.section_length  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        stg_pkg::REG_WAVEFORM_SELECT: cfg_q.waveform_select <= cfg_data_i[2:0];
        stg_pkg::REG_AMPLITUDE:       cfg_q.amplitude       <= cfg_data_i[15:0];
        stg_pkg::REG_FIXED_INCREMENT: cfg_q.fixed_increment <= cfg_data_i;
        stg_pkg::REG_SWEEP_MODE:      cfg_q.sweep_mode      <= cfg_data_i[2:0];
        stg_pkg::REG_START_INCREMENT: cfg_q.start_increment <= cfg_data_i;
        stg_pkg::REG_END_INCREMENT:   cfg_q.end_increment   <= cfg_data_i;
        stg_pkg::REG_RAMP_PERIOD:     cfg_q.ramp_period     <= cfg_data_i;
        stg_pkg::REG_SECTION_LENGTH:  cfg_q.section_length  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;
  assign cfg_o = cfg_q;

endmodule

/* hw/rtl/stg_ctrl.sv */
// Sequencer of the swept tone generator: steps the datapath through one
// request and owns the handshakes. Depends on stg_pkg for cmd_t and status_t.
module stg_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             restart_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  stg_pkg::status_t status_i,
  output stg_pkg::cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ROMRD,
    S_WAVE,
    S_MUL1,
    S_MUL2,
    S_DIV,
    S_PSEL,
    S_OFFSET,
    S_INC,
    S_FINISH
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if ((state_q == S_FINISH) && slot_free) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_ROMRD;
          end
        end
        S_ROMRD:  state_q <= S_WAVE;
        S_WAVE:   state_q <= S_MUL1;
        S_MUL1:   state_q <= S_MUL2;
        S_MUL2:   state_q <= status_i.div_needed ? S_DIV : S_PSEL;
        S_DIV: begin
          if (status_i.div_last) begin
            state_q <= S_PSEL;
          end
        end
        S_PSEL:   state_q <= S_OFFSET;
        S_OFFSET: state_q <= S_INC;
        S_INC:    state_q <= S_FINISH;
        S_FINISH: begin
          if (slot_free) begin
            state_q <= S_IDLE;
          end
        end
        default:  state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.start    = (state_q == S_IDLE) && in_valid_i;
    cmd_o.restart  = restart_i;
    cmd_o.div_load = (state_q == S_ROMRD);
    cmd_o.wave     = (state_q == S_WAVE);
    cmd_o.mul1     = (state_q == S_MUL1);
    cmd_o.mul2     = (state_q == S_MUL2);
    cmd_o.div_step = (state_q == S_DIV);
    cmd_o.psel     = (state_q == S_PSEL);
    cmd_o.offset   = (state_q == S_OFFSET);
    cmd_o.inc      = (state_q == S_INC);
    cmd_o.finish   = (state_q == S_FINISH) && slot_free;
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

/* hw/rtl/stg_datapath.sv */
// Datapath of the swept tone generator: phase and count, wave shaping, gain
// multipliers, shared restoring divider and sweep arithmetic.
// Depends on stg_pkg and stg_sine_rom.
module stg_datapath #(
  parameter int unsigned PHASE_BITS     = stg_pkg::PHASE_BITS,
  parameter int unsigned COUNT_BITS     = stg_pkg::COUNT_BITS,
  parameter int unsigned SINE_ADDR_BITS = stg_pkg::SINE_ADDR_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  stg_pkg::cfg_t      cfg_i,
  input  stg_pkg::cmd_t      cmd_i,
  output stg_pkg::status_t   status_o,
  output logic signed [15:0] sample_o,
  output logic               section_end_o
);

  localparam int unsigned PH_L = (PHASE_BITS < 32) ? 32 - PHASE_BITS : 0;
  localparam int unsigned PH_R = (PHASE_BITS >= 32) ? PHASE_BITS - 32 : 0;
  localparam int unsigned DW   = COUNT_BITS + 32;
  localparam int unsigned IW   = $clog2(DW);

  logic [PHASE_BITS-1:0]     phase_q;
  logic [COUNT_BITS-1:0]     count_q;
  logic                      sec_end_q;
  logic [30:0]               wmag_q;
  logic                      wneg_q;
  logic [46:0]               prod1_q;
  logic [61:0]               prod2_q;
  logic [DW-1:0]             dvd_q;
  logic [31:0]               rem_q;
  logic [31:0]               dvs_q;
  logic [IW-1:0]             it_q;
  logic [32:0]               q_q;
  logic [31:0]               dmag_q;
  logic                      dneg_q;
  logic [31:0]               off_q;
  logic [31:0]               inc_q;
  logic signed [15:0]        sample_q;
  logic                      section_end_q;

  logic [31:0]               ph;
  logic [1:0]                quad;
  logic [SINE_ADDR_BITS-1:0] idx;
  logic [SINE_ADDR_BITS-1:0] rom_addr;
  logic [15:0]               rom_data;
  logic [16:0]               sine_m;
  logic signed [32:0]        w_s;
  logic [30:0]               wmag_d;
  logic                      wneg_d;
  logic [31:0]               den;
  logic                      count_ge_den;
  logic                      ramp_active;
  logic [32:0]               div_sh;
  logic                      div_ge;
  logic [32:0]               p_d;
  logic [33:0]               two_p;
  logic [32:0]               q_d;
  logic signed [32:0]        s33;
  logic signed [32:0]        e33;
  logic signed [32:0]        d33;
  logic [63:0]               oprod;
  logic signed [32:0]        off33;
  logic signed [32:0]        ramp_inc;
  logic [31:0]               inc_d;
  logic signed [63:0]        inc64;
  logic signed [63:0]        step64;
  logic [62:0]               rnd;
  logic [17:0]               r;
  logic [14:0]               sat;
  logic                      audible;

  assign ph   = 32'((64'(phase_q) << PH_L) >> PH_R);
  assign quad = ph[31:30];
  assign idx  = ph[29 -: SINE_ADDR_BITS];
  assign rom_addr = quad[0] ? (SINE_ADDR_BITS'(0) - idx) : idx;

  stg_sine_rom #(
    .ADDR_BITS(SINE_ADDR_BITS)
  ) u_rom (
    .clk_i (clk_i),
    .addr_i(rom_addr),
    .data_o(rom_data)
  );

  always_comb begin
    sine_m = (quad[0] && (idx == '0)) ? 17'd32768 : {1'b0, rom_data};
    w_s = '0;
    wmag_d = '0;
    wneg_d = 1'b0;
    case (cfg_i.waveform_select)
      stg_pkg::WAVE_SINE: begin
        wmag_d = 31'({sine_m, 15'b0});
        wneg_d = quad[1];
      end
      stg_pkg::WAVE_SQUARE: begin
        wmag_d = 31'h4000_0000;
        wneg_d = ph[31];
      end
      stg_pkg::WAVE_SAWTOOTH: begin
        w_s = $signed({2'b0, ph[31:1]}) - 33'sd1073741824;
        wmag_d = w_s[32] ? 31'(-w_s) : 31'(w_s);
        wneg_d = w_s[32];
      end
      default: begin
        if (!ph[31]) begin
          w_s = $signed({1'b0, ph}) - 33'sd1073741824;
        end else begin
          w_s = 33'sd3221225472 - $signed({1'b0, ph});
        end
        wmag_d = w_s[32] ? 31'(-w_s) : 31'(w_s);
        wneg_d = w_s[32];
      end
    endcase
  end

  assign den = cfg_i.section_length - 32'd1;
  assign count_ge_den = 64'(count_q) >= 64'(den);
  assign ramp_active = (cfg_i.sweep_mode == stg_pkg::RAMP_UP) ||
                       (cfg_i.sweep_mode == stg_pkg::RAMP_DOWN) ||
                       (cfg_i.sweep_mode == stg_pkg::RAMP_BOUNCE);
  assign status_o.div_needed = ramp_active &&
      ((cfg_i.ramp_period != '0) ||
       ((cfg_i.section_length > 32'd1) && !count_ge_den));
  assign status_o.div_last = (it_q == IW'(DW - 1));

  assign div_sh = {rem_q, dvd_q[DW-1]};
  assign div_ge = div_sh >= {1'b0, dvs_q};

  always_comb begin
    if (cfg_i.ramp_period != '0) begin
      p_d = {1'b0, dvd_q[31:0]};
    end else if (cfg_i.section_length > 32'd1) begin
      p_d = count_ge_den ? 33'h1_0000_0000 : {1'b0, dvd_q[31:0]};
    end else begin
      p_d = '0;
    end
    two_p = {p_d, 1'b0};
    if (cfg_i.sweep_mode != stg_pkg::RAMP_BOUNCE) begin
      q_d = p_d;
    end else if (p_d <= 33'h0_8000_0000) begin
      q_d = two_p[32:0];
    end else begin
      q_d = 33'(34'h2_0000_0000 - two_p);
    end
  end

  assign s33 = $signed({cfg_i.start_increment[31], cfg_i.start_increment});
  assign e33 = $signed({cfg_i.end_increment[31], cfg_i.end_increment});
  assign d33 = e33 - s33;
  assign oprod = 64'(dmag_q) * 64'(q_q[31:0]);
  assign off33 = dneg_q ? -$signed({1'b0, off_q}) : $signed({1'b0, off_q});
  assign ramp_inc = (cfg_i.sweep_mode == stg_pkg::RAMP_DOWN) ? (e33 - off33) : (s33 + off33);

  always_comb begin
    case (cfg_i.sweep_mode)
      stg_pkg::RAMP_OFF:    inc_d = cfg_i.fixed_increment;
      stg_pkg::RAMP_UP,
      stg_pkg::RAMP_DOWN,
      stg_pkg::RAMP_BOUNCE: inc_d = ramp_inc[31:0];
      default:              inc_d = cfg_i.start_increment;
    endcase
  end

  assign inc64  = {{32{inc_q[31]}}, inc_q};
  assign step64 = (inc64 <<< PH_R) >>> PH_L;

  assign rnd = (63'(prod2_q) + (63'd1 << 44)) >> 45;
  assign r   = rnd[17:0];
  assign sat = (r > 18'(stg_pkg::FULL_SCALE)) ? 15'(stg_pkg::FULL_SCALE) : r[14:0];
  assign audible = (cfg_i.waveform_select == stg_pkg::WAVE_SINE) ||
                   (cfg_i.waveform_select == stg_pkg::WAVE_SQUARE) ||
                   (cfg_i.waveform_select == stg_pkg::WAVE_SAWTOOTH) ||
                   (cfg_i.waveform_select == stg_pkg::WAVE_TRIANGLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      count_q <= '0;
    end else if (cmd_i.start && cmd_i.restart) begin
      phase_q <= '0;
      count_q <= '0;
    end else if (cmd_i.finish) begin
      if (audible) begin
        phase_q <= phase_q + step64[PHASE_BITS-1:0];
      end
      count_q <= count_q + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      sec_end_q <= (cfg_i.section_length != '0) && (64'(count_q) == 64'(den));
      dvd_q <= {count_q, 32'b0};
      rem_q <= '0;
      dvs_q <= (cfg_i.ramp_period != '0) ? cfg_i.ramp_period : den;
      it_q  <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[DW-2:0], div_ge};
      rem_q <= div_ge ? 32'(div_sh - {1'b0, dvs_q}) : div_sh[31:0];
      it_q  <= it_q + IW'(1);
    end
    if (cmd_i.wave) begin
      wmag_q <= wmag_d;
      wneg_q <= wneg_d;
    end
    if (cmd_i.mul1) begin
      prod1_q <= 47'(wmag_q) * 47'(cfg_i.amplitude);
    end
    if (cmd_i.mul2) begin
      prod2_q <= 62'(prod1_q) * 62'(stg_pkg::FULL_SCALE);
    end
    if (cmd_i.psel) begin
      q_q    <= q_d;
      dmag_q <= d33[32] ? 32'(-d33) : d33[31:0];
      dneg_q <= d33[32];
    end
    if (cmd_i.offset) begin
      off_q <= q_q[32] ? dmag_q : oprod[63:32];
    end
    if (cmd_i.inc) begin
      inc_q <= inc_d;
    end
    if (cmd_i.finish) begin
      sample_q <= !audible ? 16'sd0 :
                  (wneg_q ? -$signed({1'b0, sat}) : $signed({1'b0, sat}));
      section_end_q <= sec_end_q;
    end
  end

  assign sample_o = sample_q;
  assign section_end_o = section_end_q;

endmodule

/* hw/rtl/swept_tone_generator_top.sv */
// Swept tone generator: one request in, one sample out, one request at a time.
// Once a request is accepted it passes the ROM read, wave shaping, two gain
// multiplies, the one-bit-per-cycle restoring divider when a sweep needs its
// position, and the sweep arithmetic; no new request is taken until its result
// is registered, and later while the output register still holds an untaken one.
// Reset loads the register defaults (silence) and clears phase and count.
module swept_tone_generator_top #(
  parameter int unsigned PHASE_BITS     = stg_pkg::PHASE_BITS,
  parameter int unsigned COUNT_BITS     = stg_pkg::COUNT_BITS,
  parameter int unsigned SINE_ADDR_BITS = stg_pkg::SINE_ADDR_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               restart_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] sample_o,
  output logic               section_end_o
);

  stg_pkg::cfg_t    cfg;
  stg_pkg::cmd_t    cmd;
  stg_pkg::status_t status;

  stg_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  stg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .restart_i  (restart_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  stg_datapath #(
    .PHASE_BITS    (PHASE_BITS),
    .COUNT_BITS    (COUNT_BITS),
    .SINE_ADDR_BITS(SINE_ADDR_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .status_o     (status),
    .sample_o     (sample_o),
    .section_end_o(section_end_o)
  );

endmodule

/* tb/sv/tb_swept_tone_generator_top.sv */
// Testbench for swept_tone_generator_top. A directed section and random
// phases of register writes and tick requests feed a driver, while a
// built-in tone predictor checks every output. Depends on stg_pkg and the RTL.
`timescale 1ns / 100ps

module tb_swept_tone_generator_top;

  localparam int unsigned DrainCycles = 100;
  localparam int unsigned CycleLimit  = 1000000;
  localparam logic [63:0] Two32       = 64'h1_0000_0000;

  typedef struct {
    bit         is_write;
    logic [2:0] index;
    logic [31:0] data;
    bit         restart;
  } tone_op_t;

  typedef struct {
    logic signed [15:0] sample;
    logic               section_end;
  } tone_result_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i;
  logic [31:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               restart_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [15:0] sample_o;
  logic               section_end_o;

  swept_tone_generator_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .restart_i    (restart_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_o     (sample_o),
    .section_end_o(section_end_o)
  );

  tone_op_t     pending_ops[$];
  tone_result_t expected_samples[$];
  int unsigned  error_count;
  int unsigned  quiet_cycles;
  int unsigned  cycle_count;

  // Predictor state and registers.
  logic [15:0] quarter_sine[1024];
  logic [2:0]  wave_sel;
  logic [15:0] gain;
  logic [31:0] fixed_step;
  logic [2:0]  sweep_mode;
  logic [31:0] sweep_start;
  logic [31:0] sweep_end;
  logic [31:0] sweep_period;
  logic [31:0] section_len;
  logic [31:0] phase_model;
  logic [31:0] count_model;

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic void build_quarter_sine();
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    logic [63:0] v;
    for (int k = 0; k < 1024; k++) begin
      x = (64'(k) * 64'd1686629713) >> 10;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int n = 1; n <= 8; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      v = (64'(sum) + 64'd16384) >> 15;
      if (v > 64'd32768) begin
        v = 64'd32768;
      end
      quarter_sine[k] = v[15:0];
    end
  endfunction

  function automatic longint wave_level(logic [31:0] ph);
    logic [9:0] idx;
    longint     m;
    idx = ph[29:20];
    case (wave_sel)
      stg_pkg::WAVE_SINE: begin
        if (ph[30]) begin
          m = (idx == 0) ? 32768 : longint'(quarter_sine[1024 - int'(idx)]);
        end else begin
          m = longint'(quarter_sine[idx]);
        end
        m = m * 32768;
        return ph[31] ? -m : m;
      end
      stg_pkg::WAVE_SQUARE: return ph[31] ? -(longint'(1) << 30) : (longint'(1) << 30);
      stg_pkg::WAVE_SAWTOOTH: return longint'(ph >> 1) - (longint'(1) << 30);
      default: begin
        if (!ph[31]) begin
          return longint'(ph) - (longint'(1) << 30);
        end
        return 3 * (longint'(1) << 30) - longint'(ph);
      end
    endcase
  endfunction

  function automatic logic [31:0] sweep_step(logic [31:0] count);
    longint      s;
    longint      e;
    longint      d;
    logic [63:0] p;
    logic [63:0] mag;
    longint      off;
    if (sweep_mode == stg_pkg::RAMP_OFF) begin
      return fixed_step;
    end
    s = longint'($signed(sweep_start));
    e = longint'($signed(sweep_end));
    if (sweep_mode > stg_pkg::RAMP_BOUNCE) begin
      return sweep_start;
    end
    if (sweep_period != 0) begin
      p = ((64'(count) % 64'(sweep_period)) << 32) / 64'(sweep_period);
    end else if (section_len > 1) begin
      if (64'(count) >= 64'(section_len) - 1) begin
        p = Two32;
      end else begin
        p = (64'(count) << 32) / (64'(section_len) - 1);
      end
    end else begin
      p = 0;
    end
    if (sweep_mode == stg_pkg::RAMP_BOUNCE) begin
      p = (p <= (Two32 >> 1)) ? 2 * p : 2 * Two32 - 2 * p;
    end
    d = e - s;
    mag = (d < 0) ? 64'(-d) : 64'(d);
    off = longint'((mag * p) >> 32);
    if (d < 0) begin
      off = -off;
    end
    return (sweep_mode == stg_pkg::RAMP_DOWN) ? 32'(e - off) : 32'(s + off);
  endfunction

  function automatic tone_result_t compute_tone_sample(bit restart);
    tone_result_t res;
    longint       prod;
    logic [63:0]  mag;
    longint       r;
    if (restart) begin
      phase_model = '0;
      count_model = '0;
    end
    res.section_end = (section_len != 0) && (count_model == section_len - 1);
    res.sample = '0;
    if (wave_sel <= stg_pkg::WAVE_TRIANGLE) begin
      prod = wave_level(phase_model) * longint'(gain) * 32767;
      mag = (prod < 0) ? 64'(-prod) : 64'(prod);
      r = longint'((mag + (64'd1 << 44)) >> 45);
      if (r > 32767) begin
        r = 32767;
      end
      res.sample = 16'((prod < 0) ? -r : r);
      phase_model = phase_model + sweep_step(count_model);
    end
    count_model = count_model + 1;
    return res;
  endfunction

  function automatic void write_register(logic [2:0] index, logic [31:0] data);
    case (index)
      stg_pkg::REG_WAVEFORM_SELECT: wave_sel = data[2:0];
      stg_pkg::REG_AMPLITUDE:       gain = data[15:0];
      stg_pkg::REG_FIXED_INCREMENT: fixed_step = data;
      stg_pkg::REG_SWEEP_MODE:      sweep_mode = data[2:0];
      stg_pkg::REG_START_INCREMENT: sweep_start = data;
      stg_pkg::REG_END_INCREMENT:   sweep_end = data;
      stg_pkg::REG_RAMP_PERIOD:     sweep_period = data;
      default:                      section_len = data;
    endcase
  endfunction

  function automatic void queue_write(logic [2:0] index, logic [31:0] data);
    tone_op_t op;
    op.is_write = 1'b1;
    op.index = index;
    op.data = data;
    op.restart = 1'b0;
    pending_ops.insert(pending_ops.size(), op);
  endfunction

  function automatic void queue_ticks(int n, int restart_odds);
    tone_op_t op;
    for (int i = 0; i < n; i++) begin
      op.is_write = 1'b0;
      op.index = '0;
      op.data = '0;
      op.restart = (restart_odds > 0) && ($urandom_range(0, restart_odds - 1) == 0);
      pending_ops.insert(pending_ops.size(), op);
    end
  endfunction

  function automatic logic [31:0] pick_step();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      1: return 32'($signed($urandom_range(0, 2000000)) - 1000000) <<< 8;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_length();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'd1;
      2: return $urandom;
      default: return $urandom_range(2, 40);
    endcase
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 3) == 0) begin
      return 0;
    end
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
  endfunction

  // Stimulus plan.
  initial begin
    build_quarter_sine();
    queue_ticks(2, 0);
    queue_write(stg_pkg::REG_WAVEFORM_SELECT, 32'(stg_pkg::WAVE_SINE));
    queue_write(stg_pkg::REG_AMPLITUDE, 32'd32768);
    queue_write(stg_pkg::REG_FIXED_INCREMENT, 32'h0400_0000);
    queue_write(stg_pkg::REG_SECTION_LENGTH, 32'd4);
    queue_ticks(5, 0);
    queue_ticks(1, 1);
    queue_write(stg_pkg::REG_WAVEFORM_SELECT, 32'(stg_pkg::WAVE_SQUARE));
    queue_write(stg_pkg::REG_AMPLITUDE, 32'hFFFF);
    queue_write(stg_pkg::REG_FIXED_INCREMENT, 32'h8000_0000);
    queue_ticks(2, 0);
    queue_write(stg_pkg::REG_WAVEFORM_SELECT, 32'(stg_pkg::WAVE_SAWTOOTH));
    queue_write(stg_pkg::REG_FIXED_INCREMENT, 32'h7FFF_FFFF);
    queue_ticks(2, 0);
    queue_write(stg_pkg::REG_WAVEFORM_SELECT, 32'(stg_pkg::WAVE_TRIANGLE));
    queue_write(stg_pkg::REG_SWEEP_MODE, 32'(stg_pkg::RAMP_UP));
    queue_write(stg_pkg::REG_START_INCREMENT, 32'h8000_0000);
    queue_write(stg_pkg::REG_END_INCREMENT, 32'h7FFF_FFFF);
    queue_write(stg_pkg::REG_RAMP_PERIOD, 32'd3);
    queue_ticks(3, 0);
    queue_write(stg_pkg::REG_SWEEP_MODE, 32'(stg_pkg::RAMP_DOWN));
    queue_write(stg_pkg::REG_RAMP_PERIOD, 32'd0);
    queue_write(stg_pkg::REG_SECTION_LENGTH, 32'hFFFF_FFFF);
    queue_ticks(2, 0);
    queue_write(stg_pkg::REG_SWEEP_MODE, 32'(stg_pkg::RAMP_BOUNCE));
    queue_write(stg_pkg::REG_RAMP_PERIOD, 32'hFFFF_FFFF);
    queue_write(stg_pkg::REG_SECTION_LENGTH, 32'd1);
    queue_ticks(2, 0);
    queue_write(stg_pkg::REG_SWEEP_MODE, 32'd6);
    queue_write(stg_pkg::REG_WAVEFORM_SELECT, 32'd7);
    queue_write(stg_pkg::REG_AMPLITUDE, 32'd0);
    queue_ticks(2, 0);
    queue_write(stg_pkg::REG_SWEEP_MODE, 32'(stg_pkg::RAMP_BOUNCE));
    queue_write(stg_pkg::REG_RAMP_PERIOD, 32'd0);
    queue_write(stg_pkg::REG_SECTION_LENGTH, 32'd0);
    queue_ticks(1, 0);
    for (int ph = 0; ph < 25; ph++) begin
      for (int r = 0; r < 8; r++) begin
        if (ph == 0 || $urandom_range(0, 1) == 0) begin
          case (r)
            0: queue_write(3'(r), ($urandom_range(0, 5) == 0) ? 32'($urandom_range(4, 7)) :
                                                                 32'($urandom_range(0, 3)));
            1: queue_write(3'(r), ($urandom_range(0, 3) == 0) ? $urandom :
                                                                 32'($urandom_range(0, 32768)));
            3: queue_write(3'(r), 32'($urandom_range(0, 7)));
            6: queue_write(3'(r), ($urandom_range(0, 2) == 0) ? 32'd0 : pick_length());
            7: queue_write(3'(r), pick_length());
            default: queue_write(3'(r), pick_step());
          endcase
        end
      end
      queue_ticks($urandom_range(20, 36), 12);
    end
  end

  // Driver for both request channels.
  always @(posedge clk_i or negedge rst_ni) begin
    tone_op_t op;
    bit       next_in;
    bit       next_cfg;
    static int gap = 0;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      cfg_valid_i <= 1'b0;
      restart_i <= 1'b0;
      cfg_index_i <= '0;
      cfg_data_i <= '0;
      quiet_cycles <= 0;
      wave_sel = stg_pkg::WAVE_SILENCE;
      gain = '0;
      fixed_step = '0;
      sweep_mode = stg_pkg::RAMP_OFF;
      sweep_start = '0;
      sweep_end = '0;
      sweep_period = '0;
      section_len = '0;
      phase_model = '0;
      count_model = '0;
    end else begin
      next_in = in_valid_i;
      next_cfg = cfg_valid_i;
      if (in_valid_i && in_ready_o) begin
        expected_samples.insert(expected_samples.size(), compute_tone_sample(restart_i));
        next_in = 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        write_register(cfg_index_i, cfg_data_i);
        next_cfg = 1'b0;
      end
      if (!next_in && !next_cfg && pending_ops.size() > 0) begin
        op = pending_ops[0];
        if (op.is_write) begin
          if (quiet_cycles >= DrainCycles && !in_valid_i) begin
            void'(pending_ops.pop_front());
            next_cfg = 1'b1;
            cfg_index_i <= op.index;
            cfg_data_i <= op.data;
          end
        end else if (gap > 0) begin
          gap--;
        end else begin
          void'(pending_ops.pop_front());
          next_in = 1'b1;
          restart_i <= op.restart;
          gap = pick_gap();
        end
      end
      in_valid_i <= next_in;
      cfg_valid_i <= next_cfg;
      quiet_cycles <= (expected_samples.size() == 0 && !in_valid_i && !next_in) ?
                      quiet_cycles + 1 : 0;
    end
  end

  // Output side: random stalls and comparison.
  always @(posedge clk_i or negedge rst_ni) begin
    tone_result_t want;
    static int stall = 0;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_samples.size() == 0) begin
          $error("unexpected result: sample %0d", sample_o);
          error_count++;
        end else begin
          want = expected_samples.pop_front();
          if (sample_o !== want.sample) begin
            $error("sample: expected %0d, got %0d", want.sample, sample_o);
            error_count++;
          end
          if (section_end_o !== want.section_end) begin
            $error("section_end: expected %0b, got %0b", want.section_end,
                   section_end_o);
            error_count++;
          end
        end
      end
      if (stall > 0) begin
        stall--;
        out_ready_i <= 1'b0;
      end else begin
        stall = pick_gap();
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    error_count = 0;
    cycle_count = 0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (cycle_count < CycleLimit &&
           !(pending_ops.size() == 0 && !in_valid_i && !cfg_valid_i &&
             quiet_cycles >= DrainCycles)) begin
      @(posedge clk_i);
      cycle_count++;
    end
    if (cycle_count >= CycleLimit) begin
      $display("DONE: errors detected");
    end else if (error_count == 0 && expected_samples.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/stg_pkg.sv
hw/rtl/stg_sine_rom.sv
hw/rtl/stg_regs.sv
hw/rtl/stg_ctrl.sv
hw/rtl/stg_datapath.sv
hw/rtl/swept_tone_generator_top.sv
tb/sv/tb_swept_tone_generator_top.sv
